// ===== rtl/apotc_pkg.sv =====
// ----------------------------------------------------------------------------
// apotc_pkg
// Shared constants, result type and digit helper for the command parser.
// ----------------------------------------------------------------------------
package apotc_pkg;

    localparam int unsigned LINE_CAPACITY_DEF = 19;
    localparam int unsigned NUM_CHARS         = 8;
    localparam int unsigned CHAR_IDX_W        = $clog2(NUM_CHARS);
    localparam int unsigned PERCENT_MAX_LEN   = 3;
    localparam int unsigned LEN_OUT_W         = 5;

    localparam logic [7:0] CR_BYTE    = 8'd13;
    localparam logic [7:0] ZERO_BYTE  = 8'd0;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] DEC_BASE   = 8'd10;

    typedef logic [7:0] t_char;

    typedef struct packed {
        logic [LEN_OUT_W-1:0] line_length;
        logic                 overflowed;
        logic                 is_time_pair;
        logic [7:0]           percent;
        logic [7:0]           start_hours;
        logic [7:0]           start_minutes;
        logic [7:0]           end_hours;
        logic [7:0]           end_minutes;
    } t_result;

    function automatic logic [7:0] acc_digit(input logic [7:0] acc, input logic [7:0] c);
        acc_digit = 8'(acc * DEC_BASE + c - ASCII_ZERO);
    endfunction

endpackage

// ===== rtl/apotc_parse.sv =====
// ----------------------------------------------------------------------------
// apotc_parse
// Decimal evaluation of a finished line: percentage or HHMM/HHMM pair.
// ----------------------------------------------------------------------------
module apotc_parse #(
    parameter int unsigned CNT_W = 5
) (
    input  apotc_pkg::t_char   i_chars [apotc_pkg::NUM_CHARS],
    input  logic [CNT_W-1:0]   i_len,
    input  logic               i_lost,
    output apotc_pkg::t_result o_result
);

    logic              is_time;
    logic [7:0]        pct;
    logic [7:0]        vals [4];
    apotc_pkg::t_char  c;

    always_comb begin
        is_time = i_len > CNT_W'(apotc_pkg::PERCENT_MAX_LEN);
        pct     = 8'd0;
        for (int i = 0; i < 4; i++) begin
            vals[i] = 8'd0;
        end
        c = apotc_pkg::ASCII_ZERO;
        if (is_time) begin
            for (int i = 0; i < apotc_pkg::NUM_CHARS; i++) begin
                c = (i_len > CNT_W'(i)) ? i_chars[i] : apotc_pkg::ASCII_ZERO;
                vals[i/2] = apotc_pkg::acc_digit(vals[i/2], c);
            end
        end else begin
            for (int i = 0; i < apotc_pkg::PERCENT_MAX_LEN; i++) begin
                if (i_len > CNT_W'(i)) begin
                    pct = apotc_pkg::acc_digit(pct, i_chars[i]);
                end
            end
        end
        o_result.line_length   = apotc_pkg::LEN_OUT_W'(i_len);
        o_result.overflowed    = i_lost;
        o_result.is_time_pair  = is_time;
        o_result.percent       = pct;
        o_result.start_hours   = vals[0];
        o_result.start_minutes = vals[1];
        o_result.end_hours     = vals[2];
        o_result.end_minutes   = vals[3];
    end

endmodule

// ===== rtl/ascii_percent_or_time_command_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_percent_or_time_command_parser
// Gathers received bytes into a command line and parses it on carriage return.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_rx_valid / o_rx_ready carries one received byte per
//   transfer. Every byte other than carriage return updates the line state
//   and yields nothing. A carriage return yields one result on the output
//   channel o_res_valid / i_res_ready: the line length, overflow flag, a
//   percentage for lines of up to three characters, or start/end HHMM
//   values for longer lines.
//   Throughput: one byte per cycle. Latency: the result is valid in the
//   cycle after the carriage return transfer, from the result register.
//   While a result waits, the next byte is still taken in the cycle that
//   the result transfers; a stalled receiver holds o_rx_ready low only
//   while the result register is full and not being drained.
//   Reset (synchronous, active low) clears the line state, empties the
//   result register and sets the stored leading characters to ASCII zero.
// ----------------------------------------------------------------------------
module ascii_percent_or_time_command_parser #(
    parameter int unsigned LINE_CAPACITY = apotc_pkg::LINE_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [4:0] o_line_length,
    output logic       o_overflowed,
    output logic       o_is_time_pair,
    output logic [7:0] o_percent,
    output logic [7:0] o_start_hours,
    output logic [7:0] o_start_minutes,
    output logic [7:0] o_end_hours,
    output logic [7:0] o_end_minutes
);

    localparam int unsigned CNT_W = $clog2(LINE_CAPACITY + 1);

    logic [CNT_W-1:0]   r_count;
    logic               r_zero_seen;
    logic               r_lost;
    apotc_pkg::t_char   r_chars [apotc_pkg::NUM_CHARS];
    logic               r_res_valid;
    apotc_pkg::t_result r_res;
    apotc_pkg::t_result n_res;
    logic               rx_xfer;
    logic               is_cr;

    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign rx_xfer    = i_rx_valid && o_rx_ready;
    assign is_cr      = i_rx_byte == apotc_pkg::CR_BYTE;

    apotc_parse #(
        .CNT_W(CNT_W)
    ) u_parse (
        .i_chars  (r_chars),
        .i_len    (r_count),
        .i_lost   (r_lost),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_zero_seen <= 1'b0;
            r_lost      <= 1'b0;
            r_res_valid <= 1'b0;
            for (int i = 0; i < apotc_pkg::NUM_CHARS; i++) begin
                r_chars[i] <= apotc_pkg::ASCII_ZERO;
            end
        end else begin
            if (rx_xfer && is_cr) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (rx_xfer) begin
                if (is_cr) begin
                    r_res       <= n_res;
                    r_count     <= '0;
                    r_zero_seen <= 1'b0;
                    r_lost      <= 1'b0;
                end else if (!r_zero_seen) begin
                    if (i_rx_byte == apotc_pkg::ZERO_BYTE) begin
                        r_zero_seen <= 1'b1;
                    end else if (r_count >= CNT_W'(LINE_CAPACITY)) begin
                        r_lost <= 1'b1;
                    end else begin
                        if (r_count < CNT_W'(apotc_pkg::NUM_CHARS)) begin
                            r_chars[r_count[apotc_pkg::CHAR_IDX_W-1:0]] <= i_rx_byte;
                        end
                        r_count <= r_count + 1'b1;
                    end
                end
            end
        end
    end

    assign o_res_valid     = r_res_valid;
    assign o_line_length   = r_res.line_length;
    assign o_overflowed    = r_res.overflowed;
    assign o_is_time_pair  = r_res.is_time_pair;
    assign o_percent       = r_res.percent;
    assign o_start_hours   = r_res.start_hours;
    assign o_start_minutes = r_res.start_minutes;
    assign o_end_hours     = r_res.end_hours;
    assign o_end_minutes   = r_res.end_minutes;

endmodule

// ===== verif/tb_ascii_percent_or_time_command_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii_percent_or_time_command_parser
// Drives received bytes into the command parser and checks every parsed line.
// A local line model tracks length, zero cut-off, overflow and the leading
// characters. On each carriage return transfer it queues the expected
// percentage or HHMM pair. Directed lines cover the corner cases, then random
// lines and noise run under changing idle patterns and a long output stall.
// ----------------------------------------------------------------------------
module tb_ascii_percent_or_time_command_parser;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_rx_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_res_ready = 1'b0;
    logic       o_rx_ready;
    logic       o_res_valid;
    logic [4:0] o_line_length;
    logic       o_overflowed;
    logic       o_is_time_pair;
    logic [7:0] o_percent;
    logic [7:0] o_start_hours;
    logic [7:0] o_start_minutes;
    logic [7:0] o_end_hours;
    logic [7:0] o_end_minutes;

    ascii_percent_or_time_command_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_line_length   (o_line_length),
        .o_overflowed    (o_overflowed),
        .o_is_time_pair  (o_is_time_pair),
        .o_percent       (o_percent),
        .o_start_hours   (o_start_hours),
        .o_start_minutes (o_start_minutes),
        .o_end_hours     (o_end_hours),
        .o_end_minutes   (o_end_minutes)
    );

    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    int      stall_cycles = 0;
    int      bytes_sent = 0;
    int      fail_count = 0;

    int                 line_count = 0;
    bit                 line_zero = 1'b0;
    bit                 line_lost = 1'b0;
    apotc_pkg::t_char   line_head [apotc_pkg::NUM_CHARS];

    apotc_pkg::t_result pending_results [$];
    apotc_pkg::t_result want;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        foreach (line_head[i]) line_head[i] = apotc_pkg::ASCII_ZERO;
    end

    function automatic logic [7:0] decimal_shift(input logic [7:0] acc, input logic [7:0] c);
        int sum;
        sum = int'(acc) * int'(apotc_pkg::DEC_BASE) + int'(c) - int'(apotc_pkg::ASCII_ZERO);
        return sum[7:0];
    endfunction

    task automatic track_line_byte(input logic [7:0] b);
        apotc_pkg::t_result r;
        logic [7:0]         part [4];
        logic [7:0]         c;
        logic [7:0]         pct;
        if (b != apotc_pkg::CR_BYTE) begin
            if (!line_zero) begin
                if (b == apotc_pkg::ZERO_BYTE) begin
                    line_zero = 1'b1;
                end else if (line_count >= apotc_pkg::LINE_CAPACITY_DEF) begin
                    line_lost = 1'b1;
                end else begin
                    if (line_count < apotc_pkg::NUM_CHARS) line_head[line_count] = b;
                    line_count++;
                end
            end
        end else begin
            foreach (part[i]) part[i] = 8'h00;
            pct = 8'h00;
            if (line_count > apotc_pkg::PERCENT_MAX_LEN) begin
                for (int i = 0; i < apotc_pkg::NUM_CHARS; i++) begin
                    c = (i < line_count) ? line_head[i] : apotc_pkg::ASCII_ZERO;
                    part[i/2] = decimal_shift(part[i/2], c);
                end
            end else begin
                for (int i = 0; i < line_count; i++) pct = decimal_shift(pct, line_head[i]);
            end
            r.line_length   = line_count[apotc_pkg::LEN_OUT_W-1:0];
            r.overflowed    = line_lost;
            r.is_time_pair  = (line_count > apotc_pkg::PERCENT_MAX_LEN);
            r.percent       = pct;
            r.start_hours   = part[0];
            r.start_minutes = part[1];
            r.end_hours     = part[2];
            r.end_minutes   = part[3];
            pending_results.push_back(r);
            line_count = 0;
            line_zero  = 1'b0;
            line_lost  = 1'b0;
        end
    endtask

    task automatic send_rx(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        bytes_sent++;
        track_line_byte(b);
    endtask

    task automatic send_line_text(input string s);
        for (int i = 0; i < s.len(); i++) send_rx(s[i]);
        send_rx(apotc_pkg::CR_BYTE);
    endtask

    function automatic logic [7:0] pick_non_cr();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == apotc_pkg::CR_BYTE) b = 8'($urandom_range(255));
        return b;
    endfunction

    task automatic send_random_line();
        int         kind;
        int         len;
        int         pick;
        logic [7:0] b;
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 12)) begin
                b = ($urandom_range(19) == 0) ? apotc_pkg::CR_BYTE : 8'($urandom_range(255));
                send_rx(b);
            end
        end else begin
            pick = $urandom_range(99);
            if (pick < 25)      len = $urandom_range(0, 3);
            else if (pick < 45) len = $urandom_range(4, 7);
            else if (pick < 75) len = 8;
            else                len = $urandom_range(9, 24);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(99);
                if (pick < 85)      b = apotc_pkg::ASCII_ZERO + 8'($urandom_range(9));
                else if (pick < 96) b = pick_non_cr();
                else                b = apotc_pkg::ZERO_BYTE;
                send_rx(b);
            end
            send_rx(apotc_pkg::CR_BYTE);
        end
    endtask

    task automatic test_empty_line();
        send_rx(apotc_pkg::CR_BYTE);
    endtask

    task automatic test_percent_lines();
        send_line_text("999");
        send_line_text("0");
        send_rx(8'hFF);
        send_rx(8'h01);
        send_rx(apotc_pkg::CR_BYTE);
    endtask

    task automatic test_time_lines();
        send_line_text("12345678");
        send_line_text("99999999");
    endtask

    task automatic test_short_time_line();
        send_line_text("4321");
    endtask

    task automatic test_zero_byte();
        send_rx("7");
        send_rx(apotc_pkg::ZERO_BYTE);
        send_rx("5");
        send_rx(apotc_pkg::ZERO_BYTE);
        send_rx(apotc_pkg::CR_BYTE);
    endtask

    task automatic test_overflow();
        send_line_text("1234567890123456789");
        send_line_text("2359000012345678901234");
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        int start;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = bytes_sent;
        while (bytes_sent - start < 600) send_random_line();
    endtask

    task automatic test_result_backpressure();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        stall_cycles = 400;
        repeat (40) send_line_text("5");
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_cycles > 0) begin
                i_res_ready <= 1'b0;
                stall_cycles--;
            end else begin
                i_res_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch %s: expected %0d, actual %0d", name, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected result transfer");
            end else begin
                want = pending_results.pop_front();
                check_field("line_length", want.line_length, o_line_length);
                check_field("overflowed", want.overflowed, o_overflowed);
                check_field("is_time_pair", want.is_time_pair, o_is_time_pair);
                check_field("percent", want.percent, o_percent);
                check_field("start_hours", want.start_hours, o_start_hours);
                check_field("start_minutes", want.start_minutes, o_start_minutes);
                check_field("end_hours", want.end_hours, o_end_hours);
                check_field("end_minutes", want.end_minutes, o_end_minutes);
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_line();
        test_percent_lines();
        test_time_lines();
        test_short_time_line();
        test_zero_byte();
        test_overflow();
        test_random_traffic(20, 83);
        test_random_traffic(83, 20);
        test_random_traffic(0, 0);
        test_result_backpressure();
        i_rx_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
